// File: sv/edge_triggered_event_log_filter_defines.svh
// Assertion macros for the event log filter.
// Included by the top level; needs only a clock and an active-low reset.
`ifndef EDGE_TRIGGERED_EVENT_LOG_FILTER_DEFINES_SVH
`define EDGE_TRIGGERED_EVENT_LOG_FILTER_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define ETELF_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset.
`define ETELF_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/etelf_pkg.sv
// Shared constants, types and helpers for the event log filter.
// No dependencies; used by every other file of the block but the assertion macro header.
`default_nettype none

package etelf_pkg;

    localparam int RULE_SLOTS_DEF  = 32;
    localparam int GROUP_COUNT_DEF = 4;

    localparam int MODE_W     = 2;
    localparam int CODE_W     = 12;
    localparam int LEVEL_W    = 3;
    localparam int TIME_W     = 32;
    localparam int SLOT_W     = 5;
    localparam int GROUP_IN_W = 2;
    localparam int INTERVAL_W = 31;
    localparam int COUNT_W    = 32;
    localparam int REPORT_W   = 15;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [REPORT_W-1:0] REPORT_MAX = 15'd32767;

    // Item modes
    localparam logic [MODE_W-1:0] MODE_EVENT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POLL  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RULE  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HEARTBEAT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPORT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WARN      = 2'd2;

    localparam logic [INTERVAL_W-1:0] HEARTBEAT_RST = 31'd3600000;
    localparam logic [INTERVAL_W-1:0] REPORT_RST    = 31'd60000;
    localparam logic [LEVEL_W-1:0]    WARN_RST      = 3'd3;

    typedef struct packed {
        logic load;   // capture the input item
        logic rd;     // read one rule slot
        logic eval;   // register the interval tests
        logic apply;  // update state and load the result register
    } etelf_cmd_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
    } etelf_sts_t;

    // Reduce a 2-bit group number modulo the group count.
    function automatic logic [GROUP_IN_W-1:0] grp_reduce(input logic [GROUP_IN_W-1:0] g,
                                                         input int unsigned n);
        logic [GROUP_IN_W-1:0] v;
        v = g;
        for (int k = 0; k < 3; k++) begin
            if (int'(v) >= n) begin
                v = v - GROUP_IN_W'(n);
            end
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// File: sv/etelf_if.sv
// Channel interfaces of the event log filter: input items, results, config writes.
// Widths come from etelf_pkg.
`default_nettype none

interface etelf_in_if;
    logic                              valid;
    logic                              ready;
    logic [etelf_pkg::MODE_W-1:0]      mode;
    logic [etelf_pkg::CODE_W-1:0]      code;
    logic [etelf_pkg::LEVEL_W-1:0]     level;
    logic [etelf_pkg::TIME_W-1:0]      now_ms;
    logic [etelf_pkg::SLOT_W-1:0]      rule_slot;
    logic                              rule_valid;
    logic [etelf_pkg::GROUP_IN_W-1:0]  rule_group;
    logic                              rule_fault;

    modport source (output valid, mode, code, level, now_ms, rule_slot, rule_valid,
                    rule_group, rule_fault, input ready);
    modport sink   (input valid, mode, code, level, now_ms, rule_slot, rule_valid,
                    rule_group, rule_fault, output ready);
endinterface

interface etelf_out_if;
    logic                            valid;
    logic                            ready;
    logic                            persist;
    logic [etelf_pkg::REPORT_W-1:0]  report_count;

    modport source (output valid, persist, report_count, input ready);
    modport sink   (input valid, persist, report_count, output ready);
endinterface

interface etelf_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [etelf_pkg::CFG_IDX_W-1:0]   index;
    logic [etelf_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: sv/edge_triggered_event_log_filter.sv
// Top level of the event log filter: joins the sequencer and the datapath
// to the input, result and configuration channels. Depends on etelf_pkg,
// etelf_if, etelf_ctrl, etelf_dp and the assertion macro header.
`default_nettype none
`include "edge_triggered_event_log_filter_defines.svh"

// One item is in work at a time and each item yields exactly one result.
// A log event scans the rule table one slot per cycle through the single read
// port of the rule memory, then goes through evaluation and update before the
// next item can transfer. Report polls, rule writes and the unused mode skip
// the scan. The result sits in an output register, so the next item is taken
// while a result still waits; a new result is held back only while the
// previous one has not been taken. Configuration writes are always ready and
// take effect on the next cycle.

module edge_triggered_event_log_filter #(
    parameter int RULE_SLOTS  = etelf_pkg::RULE_SLOTS_DEF,
    parameter int GROUP_COUNT = etelf_pkg::GROUP_COUNT_DEF
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    etelf_in_if.sink     in_ch,
    etelf_out_if.source  out_ch,
    etelf_cfg_if.sink    cfg
);

    localparam int AW = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;

    etelf_pkg::etelf_cmd_t cmd;
    etelf_pkg::etelf_sts_t sts;
    logic [AW-1:0]         rd_addr;

    assign cfg.ready = 1'b1;

    etelf_ctrl #(
        .RULE_SLOTS (RULE_SLOTS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .sts       (sts),
        .cmd       (cmd),
        .rd_addr   (rd_addr)
    );

    etelf_dp #(
        .RULE_SLOTS  (RULE_SLOTS),
        .GROUP_COUNT (GROUP_COUNT)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .rd_addr      (rd_addr),
        .sts          (sts),
        .mode         (in_ch.mode),
        .code         (in_ch.code),
        .level        (in_ch.level),
        .now_ms       (in_ch.now_ms),
        .rule_slot    (in_ch.rule_slot),
        .rule_valid   (in_ch.rule_valid),
        .rule_group   (in_ch.rule_group),
        .rule_fault   (in_ch.rule_fault),
        .cfg_we       (cfg.valid),
        .cfg_index    (cfg.index),
        .cfg_data     (cfg.data),
        .persist      (out_ch.persist),
        .report_count (out_ch.report_count)
    );

    // A transfer in starts work: no second item until this one is done.
    `ETELF_ASSERT_NEXT(a_busy_after_load, clk, rst_n, in_ch.valid && in_ch.ready, !in_ch.ready, "input ready right after a transfer")
    // A result is loaded only when the result register is free.
    `ETELF_ASSERT_NOW(a_no_overwrite, clk, rst_n, cmd.apply, !out_ch.valid || out_ch.ready, "result register overwritten")
    // A loaded result is offered on the next cycle.
    `ETELF_ASSERT_NEXT(a_result_shown, clk, rst_n, cmd.apply, out_ch.valid, "loaded result not offered")

endmodule

`default_nettype wire

// File: sv/etelf_ctrl.sv
// Sequencer of the event log filter: accepts items, steps the rule scan,
// orders evaluation and update, and owns the result valid flag.
// Depends on etelf_pkg.
`default_nettype none

module etelf_ctrl #(
    parameter int RULE_SLOTS = etelf_pkg::RULE_SLOTS_DEF,
    localparam int AW = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1,
    localparam int CW = $clog2(RULE_SLOTS + 1)
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    input  wire etelf_pkg::etelf_sts_t sts,
    output etelf_pkg::etelf_cmd_t      cmd,
    output logic [AW-1:0]              rd_addr
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_EVAL  = 2'd2;
    localparam logic [1:0] S_APPLY = 2'd3;

    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          out_valid_reg, out_valid_next;
    logic          scan_done;

    assign scan_done = (idx_reg == CW'(RULE_SLOTS));
    assign rd_addr   = idx_reg[AW-1:0];
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    idx_next   = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // Only events look up the rule table; the last compare lands
                // in the cycle that leaves this state.
                if (sts.mode != etelf_pkg::MODE_EVENT || scan_done)
                begin
                    state_next = S_EVAL;
                end
                else
                begin
                    cmd.rd   = 1'b1;
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                // Hold until the result register is free.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.apply  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.apply)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/etelf_dp.sv
// Datapath of the event log filter: configuration registers, rule memory,
// group state, suppression counter and the result register.
// Depends on etelf_pkg; driven by etelf_ctrl commands.
`default_nettype none

module etelf_dp #(
    parameter int RULE_SLOTS  = etelf_pkg::RULE_SLOTS_DEF,
    parameter int GROUP_COUNT = etelf_pkg::GROUP_COUNT_DEF,
    localparam int AW = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1,
    localparam int GW = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire etelf_pkg::etelf_cmd_t                cmd,
    input  wire logic [AW-1:0]                        rd_addr,
    output etelf_pkg::etelf_sts_t                     sts,
    input  wire logic [etelf_pkg::MODE_W-1:0]         mode,
    input  wire logic [etelf_pkg::CODE_W-1:0]         code,
    input  wire logic [etelf_pkg::LEVEL_W-1:0]        level,
    input  wire logic [etelf_pkg::TIME_W-1:0]         now_ms,
    input  wire logic [etelf_pkg::SLOT_W-1:0]         rule_slot,
    input  wire logic                                 rule_valid,
    input  wire logic [etelf_pkg::GROUP_IN_W-1:0]     rule_group,
    input  wire logic                                 rule_fault,
    input  wire logic                                 cfg_we,
    input  wire logic [etelf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [etelf_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                                      persist,
    output logic [etelf_pkg::REPORT_W-1:0]            report_count
);

    localparam int CODE_W = etelf_pkg::CODE_W;
    localparam int TIME_W = etelf_pkg::TIME_W;
    localparam int IVL_W  = etelf_pkg::INTERVAL_W;
    localparam int CNT_W  = etelf_pkg::COUNT_W;
    localparam int ENT_W  = CODE_W + GW + 1;
    localparam int SLOT_X = 9;

    // Configuration
    logic [IVL_W-1:0]              hb_ivl_reg;
    logic [IVL_W-1:0]              rp_ivl_reg;
    logic [etelf_pkg::LEVEL_W-1:0] warn_reg;

    // Captured item
    logic [etelf_pkg::MODE_W-1:0]     mode_reg;
    logic [CODE_W-1:0]                code_reg;
    logic [etelf_pkg::LEVEL_W-1:0]    level_reg;
    logic [TIME_W-1:0]                now_reg;
    logic [etelf_pkg::SLOT_W-1:0]     slot_reg;
    logic                             rvalid_reg;
    logic [etelf_pkg::GROUP_IN_W-1:0] rgroup_reg;
    logic                             rfault_reg;

    // Rule table
    logic [ENT_W-1:0]      rule_mem [RULE_SLOTS];
    logic [RULE_SLOTS-1:0] rule_vld_reg;
    logic [ENT_W-1:0]      rd_data_reg;
    logic                  rd_vld_reg;
    logic                  rd_pend_reg;
    logic                  hit_reg;
    logic [GW-1:0]         hit_group_reg;
    logic                  hit_fault_reg;

    // Group and report state
    logic              seen_reg   [GROUP_COUNT];
    logic              faulty_reg [GROUP_COUNT];
    logic [TIME_W-1:0] last_reg   [GROUP_COUNT];
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [TIME_W-1:0] win_reg, win_next;
    logic              armed_reg, armed_next;
    logic              hb_pass_reg;
    logic              rp_pass_reg;

    logic                           persist_reg;
    logic [etelf_pkg::REPORT_W-1:0] report_reg;

    logic [TIME_W-1:0]       hb_diff, rp_diff;
    logic [SLOT_X-1:0]       slot_ext;
    logic                    slot_ok;
    logic [AW-1:0]           wr_addr;
    logic [GW-1:0]           wr_group;
    logic                    rule_we;
    logic                    upd_fault, upd_first, upd_hb, upd_supp, upd_report;
    logic                    persist_next;
    logic [etelf_pkg::REPORT_W-1:0] report_next;

    assign sts.mode = mode_reg;

    // Configuration writes; unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hb_ivl_reg <= etelf_pkg::HEARTBEAT_RST;
            rp_ivl_reg <= etelf_pkg::REPORT_RST;
            warn_reg   <= etelf_pkg::WARN_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                etelf_pkg::CFG_HEARTBEAT: hb_ivl_reg <= cfg_data[IVL_W-1:0];
                etelf_pkg::CFG_REPORT:    rp_ivl_reg <= cfg_data[IVL_W-1:0];
                etelf_pkg::CFG_WARN:      warn_reg   <= cfg_data[etelf_pkg::LEVEL_W-1:0];
                default:                  ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg   <= mode;
            code_reg   <= code;
            level_reg  <= level;
            now_reg    <= now_ms;
            slot_reg   <= rule_slot;
            rvalid_reg <= rule_valid;
            rgroup_reg <= rule_group;
            rfault_reg <= rule_fault;
        end
    end

    // Rule writes
    assign slot_ext = SLOT_X'(slot_reg);
    assign slot_ok  = (slot_ext < SLOT_X'(RULE_SLOTS));
    assign wr_addr  = slot_ext[AW-1:0];
    assign wr_group = GW'(etelf_pkg::grp_reduce(rgroup_reg, GROUP_COUNT));
    assign rule_we  = cmd.apply && (mode_reg == etelf_pkg::MODE_RULE) && slot_ok;

    always_ff @(posedge clk)
    begin
        if (rule_we)
        begin
            rule_mem[wr_addr] <= {code_reg, wr_group, rfault_reg};
        end
        if (cmd.rd)
        begin
            rd_data_reg <= rule_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rule_vld_reg <= '0;
            rd_vld_reg   <= 1'b0;
            rd_pend_reg  <= 1'b0;
            hit_reg      <= 1'b0;
        end
        else
        begin
            if (rule_we)
            begin
                rule_vld_reg[wr_addr] <= rvalid_reg;
            end
            rd_pend_reg <= cmd.rd;
            if (cmd.rd)
            begin
                rd_vld_reg <= rule_vld_reg[rd_addr];
            end
            // Lowest matching slot wins: freeze on the first hit.
            if (cmd.load)
            begin
                hit_reg <= 1'b0;
            end
            else if (rd_pend_reg && !hit_reg && rd_vld_reg
                     && rd_data_reg[ENT_W-1 -: CODE_W] == code_reg)
            begin
                hit_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_pend_reg && !hit_reg)
        begin
            hit_group_reg <= rd_data_reg[GW:1];
            hit_fault_reg <= rd_data_reg[0];
        end
    end

    // Wrap-safe interval tests: the difference must be non-negative as signed.
    assign hb_diff = now_reg - last_reg[hit_group_reg];
    assign rp_diff = now_reg - win_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.eval)
        begin
            hb_pass_reg <= !hb_diff[TIME_W-1] && (hb_diff[IVL_W-1:0] >= hb_ivl_reg);
            rp_pass_reg <= !rp_diff[TIME_W-1] && (rp_diff[IVL_W-1:0] >= rp_ivl_reg);
        end
    end

    // Event and poll decisions
    always_comb
    begin
        upd_fault    = 1'b0;
        upd_first    = 1'b0;
        upd_hb       = 1'b0;
        upd_supp     = 1'b0;
        upd_report   = 1'b0;
        persist_next = 1'b0;
        report_next  = '0;
        cnt_next     = cnt_reg;
        win_next     = win_reg;
        armed_next   = armed_reg;
        case (mode_reg)
            etelf_pkg::MODE_EVENT:
            begin
                persist_next = 1'b1;
                if (hit_reg && hit_fault_reg)
                begin
                    upd_fault = 1'b1;
                end
                else if (level_reg >= warn_reg || !hit_reg)
                begin
                    upd_fault = 1'b0;
                end
                else if (!seen_reg[hit_group_reg] || faulty_reg[hit_group_reg])
                begin
                    upd_first = 1'b1;
                end
                else if (hb_pass_reg)
                begin
                    upd_hb = 1'b1;
                end
                else
                begin
                    upd_supp     = 1'b1;
                    persist_next = 1'b0;
                    if (cnt_reg == '0)
                    begin
                        win_next   = now_reg;
                        armed_next = 1'b1;
                    end
                    if (cnt_reg != '1)
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            etelf_pkg::MODE_POLL:
            begin
                if (armed_reg && cnt_reg != '0 && rp_pass_reg)
                begin
                    upd_report  = 1'b1;
                    cnt_next    = '0;
                    armed_next  = 1'b0;
                    report_next = (cnt_reg > CNT_W'(etelf_pkg::REPORT_MAX))
                                  ? etelf_pkg::REPORT_MAX
                                  : cnt_reg[etelf_pkg::REPORT_W-1:0];
                end
            end
            default:
            begin
                persist_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < GROUP_COUNT; i++)
            begin
                seen_reg[i]   <= 1'b0;
                faulty_reg[i] <= 1'b0;
                last_reg[i]   <= '0;
            end
            cnt_reg   <= '0;
            win_reg   <= '0;
            armed_reg <= 1'b0;
        end
        else if (cmd.apply)
        begin
            if (upd_fault)
            begin
                faulty_reg[hit_group_reg] <= 1'b1;
            end
            if (upd_first)
            begin
                seen_reg[hit_group_reg]   <= 1'b1;
                faulty_reg[hit_group_reg] <= 1'b0;
            end
            if (upd_first || upd_hb)
            begin
                last_reg[hit_group_reg] <= now_reg;
            end
            if (upd_supp || upd_report)
            begin
                cnt_reg   <= cnt_next;
                win_reg   <= win_next;
                armed_reg <= armed_next;
            end
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.apply)
        begin
            persist_reg <= persist_next;
            report_reg  <= report_next;
        end
    end

    assign persist      = persist_reg;
    assign report_count = report_reg;

endmodule

`default_nettype wire
